/* rtl/hrs_pkg.sv */
// shared constants for the harmonic rate selector
`timescale 1ns / 1ps
package hrs_pkg;

  // storage sizes
  localparam int TRACE_DEPTH = 5;
  localparam int MAX_STREAMS = 16;

  // ring and table index widths
  localparam int TRACE_AW = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
  localparam int TRACE_CW = $clog2(TRACE_DEPTH + 1);
  localparam int TBL_AW   = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int TBL_CW   = $clog2(MAX_STREAMS + 1);

  // data widths
  localparam int RATE_W  = 32;
  localparam int INDEX_W = 4;
  localparam int SCNT_W  = 5;

  // fixed point reciprocal, 56 fraction bits
  localparam int RECIP_SHIFT = 56;

  // shared divider: 60 bit operands, two quotient bits per cycle
  localparam int DIV_W     = 60;
  localparam int DIV_STEP  = 2;
  localparam int DIV_ITERS = DIV_W / DIV_STEP;
  localparam int DIV_CW    = $clog2(DIV_ITERS + 1);

  // distance limit for a stream to qualify
  localparam logic [RATE_W-1:0] DIST_LIMIT = 32'h1FFF_FFFF;

  // item modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_TABLE  = 2'd1;
  localparam logic [1:0] MODE_SELECT = 2'd2;

endpackage

/* rtl/hrs_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module hrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/hrs_div.sv */
// iterative restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps
module hrs_div
  import hrs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              run_r;
  logic              done_r;

  // two shift and subtract steps on the partial remainder
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int s = 0; s < DIV_STEP; s++) begin
      rem_nxt = {rem_nxt[DIV_W-1:0], quo_nxt[DIV_W-1]};
      quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_ITERS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/harmonic_rate_selector_top.sv */
// top level of the harmonic rate selector
`timescale 1ns / 1ps
// Sample and table-write items are accepted while idle and busy stays low after them.
// A select item with an empty ring gives its result on the next cycle. Otherwise
// it reads each stored sample from the ring and forms its reciprocal in the
// shared two-bit-per-cycle divider, then does the final division, then scans
// each table entry (one ram read, one compare) and finishes; busy is high for
// that time. The result appears for one cycle with out_valid in the cycle after
// the finishing step and cannot be held off.
module harmonic_rate_selector_top
  import hrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [RATE_W-1:0]   in_sample_rate,
  input  logic [3:0]          in_table_slot,
  input  logic [RATE_W-1:0]   in_slot_bandwidth,
  input  logic                cfg_we,
  input  logic [SCNT_W-1:0]   cfg_wdata,
  output logic                out_valid,
  output logic [INDEX_W-1:0]  out_chosen_index,
  output logic [RATE_W-1:0]   out_predicted_rate,
  output logic                out_trace_empty
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RRD   = 4'd1;
  localparam logic [3:0] ST_RDATA = 4'd2;
  localparam logic [3:0] ST_RDIV  = 4'd3;
  localparam logic [3:0] ST_QGO   = 4'd4;
  localparam logic [3:0] ST_QDIV  = 4'd5;
  localparam logic [3:0] ST_TRD   = 4'd6;
  localparam logic [3:0] ST_TCMP  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [SCNT_W-1:0]   stream_count_r;
  logic [TRACE_CW-1:0] sample_count_r;
  logic [TRACE_AW-1:0] write_pointer_r;
  logic [TRACE_CW-1:0] ring_idx_r, ring_idx_nxt;
  logic [TBL_CW-1:0]   tbl_idx_r, tbl_idx_nxt;
  logic [TBL_CW-1:0]   scan_n;
  logic [DIV_W-1:0]    sum_r, sum_nxt;
  logic [RATE_W-1:0]   pred_r, pred_nxt;
  logic [RATE_W-1:0]   best_r, best_nxt;
  logic [INDEX_W-1:0]  choice_r, choice_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [RATE_W-1:0]   out_rate_r, out_rate_nxt;
  logic                out_empty_r, out_empty_nxt;

  logic                accept;
  logic                ring_we;
  logic [RATE_W-1:0]   ring_rdata;
  logic                tbl_we;
  logic [RATE_W-1:0]   tbl_rdata;
  logic                div_go;
  logic [DIV_W-1:0]    div_dividend, div_divisor, div_quotient;
  logic                div_done;
  logic [RATE_W-1:0]   tbl_dist;
  logic [RATE_W-1:0]   pred_sat;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // write side of both stores
  assign ring_we = accept && (in_mode == MODE_SAMPLE) && (in_sample_rate != '0);
  assign tbl_we  = accept && (in_mode == MODE_TABLE) && (int'(in_table_slot) < MAX_STREAMS);

  hrs_ram #(
    .WIDTH (RATE_W),
    .DEPTH (TRACE_DEPTH),
    .AW    (TRACE_AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_pointer_r),
    .wdata (in_sample_rate),
    .raddr (ring_idx_r[TRACE_AW-1:0]),
    .rdata (ring_rdata)
  );

  hrs_ram #(
    .WIDTH (RATE_W),
    .DEPTH (MAX_STREAMS),
    .AW    (TBL_AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TBL_AW'(in_table_slot)),
    .wdata (in_slot_bandwidth),
    .raddr (tbl_idx_r[TBL_AW-1:0]),
    .rdata (tbl_rdata)
  );

  // shared divider: reciprocals, then the final quotient
  assign div_go = (state_r == ST_RDATA) || (state_r == ST_QGO);
  assign div_dividend = (state_r == ST_QGO) ?
                        (DIV_W'(sample_count_r) << RECIP_SHIFT) :
                        (DIV_W'(1) << RECIP_SHIFT);
  assign div_divisor  = (state_r == ST_QGO) ? sum_r : DIV_W'(ring_rdata);

  hrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // number of table entries to scan
  assign scan_n = (int'(stream_count_r) > MAX_STREAMS) ? TBL_CW'(MAX_STREAMS)
                                                        : TBL_CW'(stream_count_r);

  // saturated prediction and distance to the current table entry
  assign pred_sat = (div_quotient[DIV_W-1:RATE_W] != '0) ? '1
                                                          : div_quotient[RATE_W-1:0];
  assign tbl_dist = (tbl_rdata >= pred_r) ? (tbl_rdata - pred_r) : (pred_r - tbl_rdata);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ring_idx_nxt  = ring_idx_r;
    tbl_idx_nxt   = tbl_idx_r;
    sum_nxt       = sum_r;
    pred_nxt      = pred_r;
    best_nxt      = best_r;
    choice_nxt    = choice_r;
    out_valid_nxt = 1'b0;
    out_index_nxt = out_index_r;
    out_rate_nxt  = out_rate_r;
    out_empty_nxt = out_empty_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_SELECT)) begin
          if (sample_count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_index_nxt = '0;
            out_rate_nxt  = '0;
            out_empty_nxt = 1'b1;
          end else begin
            ring_idx_nxt = '0;
            sum_nxt      = '0;
            state_nxt    = ST_RRD;
          end
        end
      end
      ST_RRD: begin
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        state_nxt = ST_RDIV;
      end
      ST_RDIV: begin
        if (div_done) begin
          sum_nxt      = sum_r + div_quotient;
          ring_idx_nxt = ring_idx_r + 1'b1;
          state_nxt    = (ring_idx_nxt == sample_count_r) ? ST_QGO : ST_RRD;
        end
      end
      ST_QGO: begin
        state_nxt = ST_QDIV;
      end
      ST_QDIV: begin
        if (div_done) begin
          pred_nxt    = pred_sat;
          best_nxt    = DIST_LIMIT;
          choice_nxt  = '0;
          tbl_idx_nxt = '0;
          state_nxt   = (scan_n == '0) ? ST_FIN : ST_TRD;
        end
      end
      ST_TRD: begin
        state_nxt = ST_TCMP;
      end
      ST_TCMP: begin
        if (tbl_dist < best_r) begin
          best_nxt   = tbl_dist;
          choice_nxt = INDEX_W'(tbl_idx_r);
        end
        tbl_idx_nxt = tbl_idx_r + 1'b1;
        state_nxt   = (tbl_idx_nxt == scan_n) ? ST_FIN : ST_TRD;
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_index_nxt = choice_r;
        out_rate_nxt  = pred_r;
        out_empty_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      stream_count_r  <= SCNT_W'(1);
      sample_count_r  <= '0;
      write_pointer_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        stream_count_r <= cfg_wdata;
      end
      // ring bookkeeping for a stored sample
      if (ring_we) begin
        write_pointer_r <= (int'(write_pointer_r) == TRACE_DEPTH - 1) ? '0
                                                                       : write_pointer_r + 1'b1;
        if (int'(sample_count_r) < TRACE_DEPTH) begin
          sample_count_r <= sample_count_r + 1'b1;
        end
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    ring_idx_r  <= ring_idx_nxt;
    tbl_idx_r   <= tbl_idx_nxt;
    sum_r       <= sum_nxt;
    pred_r      <= pred_nxt;
    best_r      <= best_nxt;
    choice_r    <= choice_nxt;
    out_index_r <= out_index_nxt;
    out_rate_r  <= out_rate_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_chosen_index   = out_index_r;
  assign out_predicted_rate = out_rate_r;
  assign out_trace_empty    = out_empty_r;

endmodule
